// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the UART ring buffer block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ----- rtl/urbif_pkg.sv -----
// ----------------------------------------------------------------------------
// urbif_pkg
// Types, constants and helpers shared by the UART ring buffer block.
// ----------------------------------------------------------------------------
`default_nettype none

package urbif_pkg;

   localparam int RING_DEPTH = 128;
   localparam int IDX_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int FILL_W     = $clog2(RING_DEPTH + 1);

   localparam logic [7:0] CH_CR      = 8'h0D;
   localparam logic [7:0] CH_LF      = 8'h0A;
   localparam logic [7:0] IDLE_RESET = 8'd5;

   typedef logic [IDX_W-1:0]  idx_type;
   typedef logic [FILL_W-1:0] fill_type;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_LINE  = 2'd2,
      OP_TICK  = 2'd3
   } opcode_type;

   typedef struct packed {
      logic push;
      logic pop;
   } ring_ctl_type;

   typedef struct packed {
      fill_type fill;
      logic     full;
      logic     empty;
   } ring_stat_type;

   function automatic idx_type next_idx(idx_type i);
      if (i == idx_type'(RING_DEPTH - 1)) begin
         return '0;
      end
      return i + idx_type'(1);
   endfunction

   // Saturate a fill count to one byte.
   function automatic logic [7:0] sat_count(fill_type n);
      logic [FILL_W+8:0] nw;
      nw = (FILL_W + 9)'(n);
      if (nw > (FILL_W + 9)'(255)) begin
         return 8'hFF;
      end
      return nw[7:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/urbif_ring.sv -----
// ----------------------------------------------------------------------------
// urbif_ring
// Byte ring: one synchronous memory with head, tail and fill count.
// Pop data appears in the read register in the cycle after the pop.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module urbif_ring (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire urbif_pkg::ring_ctl_type ctl,
   input  wire logic [7:0]              push_data,
   output      urbif_pkg::ring_stat_type status,
   output      logic [7:0]              rd_data
);

   logic [7:0] mem [urbif_pkg::RING_DEPTH];

   urbif_pkg::idx_type  head_ff, head_in;
   urbif_pkg::idx_type  tail_ff, tail_in;
   urbif_pkg::fill_type fill_ff, fill_in;
   logic [7:0]          rd_data_ff;

   always_comb begin
      head_in = ctl.push ? urbif_pkg::next_idx(head_ff) : head_ff;
      tail_in = ctl.pop  ? urbif_pkg::next_idx(tail_ff) : tail_ff;
      case ({ctl.push, ctl.pop})
         2'b10:   fill_in = fill_ff + urbif_pkg::fill_type'(1);
         2'b01:   fill_in = fill_ff - urbif_pkg::fill_type'(1);
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[head_ff] <= push_data;
      end
      // hold read data until the next pop
      if (ctl.pop) begin
         rd_data_ff <= mem[tail_ff];
      end
   end

   assign status.fill  = fill_ff;
   assign status.full  = (fill_ff == urbif_pkg::fill_type'(urbif_pkg::RING_DEPTH));
   assign status.empty = (fill_ff == '0);
   assign rd_data      = rd_data_ff;

   `ASSERT_CLK(a_fill_max, fill_ff <= urbif_pkg::fill_type'(urbif_pkg::RING_DEPTH), "fill beyond depth")
   `ASSERT_CLK(a_empty_ptrs, (fill_ff == '0) |-> (head_ff == tail_ff), "empty ring with split pointers")
   `ASSERT_CLK(a_push_grows, (ctl.push && !ctl.pop) |=> (fill_ff == $past(fill_ff) + urbif_pkg::fill_type'(1)), "push did not grow fill")
   `ASSERT_NEVER(a_pop_empty, ctl.pop && (fill_ff == '0), "pop from empty ring")

endmodule

`default_nettype wire

// ----- rtl/uart_ring_buffers_idle_frame_top.sv -----
// ----------------------------------------------------------------------------
// uart_ring_buffers_idle_frame_top
// UART buffering unit: transmit ring, receive ring and receive idle timer.
// ----------------------------------------------------------------------------
// Each request passes the idle state, where the ring memories are written or
// read in the transfer cycle, then the work state, where the registered memory
// read data and the updated fill counts are folded into the response register.
// A host write that expands a line feed stores the carriage return in the
// transfer cycle and the line feed when work finishes. A new request is taken
// as soon as the previous response is loaded, while that response still waits
// for rsp_ready; the work state stretches only while an older response is
// still held. The rings need no clearing pass after reset. idle_ticks may be
// written at any time the block is idle; csr_ready is always high.
`default_nettype none
`include "assert_macros.svh"

module uart_ring_buffers_idle_frame_top (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic [1:0] req_opcode,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_expand_newline,
   input  wire logic       req_line_ready,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic       rsp_ok,
   output      logic [7:0] rsp_read_byte,
   output      logic       rsp_send_valid,
   output      logic [7:0] rsp_send_byte,
   output      logic       rsp_frame_ready,
   output      logic [7:0] rsp_frame_count,
   output      logic       rsp_overflow,
   input  wire logic       csr_valid,
   output      logic       csr_ready,
   input  wire logic [7:0] csr_idle_ticks
);

   typedef enum logic {
      ST_IDLE,
      ST_WORK
   } state_type;

   state_type               state_ff;
   urbif_pkg::opcode_type   op_ff;
   urbif_pkg::opcode_type   req_op;
   logic [7:0]              data_ff;
   logic                    cr_ff;
   logic                    hit_ff;
   logic                    frame_ff;
   logic                    overflow_ff;
   logic [7:0]              timer_ff, timer_in;
   logic [7:0]              idle_ticks_ff;

   logic                    rsp_valid_ff;
   logic                    rsp_ok_ff;
   logic [7:0]              rsp_read_byte_ff;
   logic                    rsp_send_valid_ff;
   logic [7:0]              rsp_send_byte_ff;
   logic                    rsp_frame_ready_ff;
   logic [7:0]              rsp_frame_count_ff;
   logic                    rsp_overflow_ff;

   urbif_pkg::ring_ctl_type  send_ctl, recv_ctl;
   urbif_pkg::ring_stat_type send_st, recv_st;
   logic [7:0]               send_push_data, send_rd, recv_rd;

   logic req_xfer;
   logic finish;
   logic need_cr;
   logic acc_hit;
   logic acc_frame;
   logic acc_overflow;
   logic fin_ok;

   assign req_op    = urbif_pkg::opcode_type'(req_opcode);
   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign finish    = (state_ff == ST_WORK) && (!rsp_valid_ff || rsp_ready);
   assign need_cr   = req_expand_newline && (req_data_byte == urbif_pkg::CH_LF);
   assign csr_ready = 1'b1;

   always_comb begin
      acc_hit      = 1'b0;
      acc_frame    = 1'b0;
      acc_overflow = 1'b0;
      timer_in     = timer_ff;
      send_ctl     = '0;
      recv_ctl     = '0;
      // transfer cycle: the carriage return or the plain byte; work state: the line feed
      send_push_data = (state_ff == ST_IDLE) ?
                       (need_cr ? urbif_pkg::CH_CR : req_data_byte) : data_ff;

      if (req_xfer) begin
         case (req_op)
            urbif_pkg::OP_WRITE: begin
               acc_hit       = !send_st.full;
               send_ctl.push = !send_st.full;
            end
            urbif_pkg::OP_READ: begin
               acc_hit      = !recv_st.empty;
               recv_ctl.pop = !recv_st.empty;
            end
            urbif_pkg::OP_LINE: begin
               // drop the byte on a full ring and end the frame at once
               acc_frame     = recv_st.full;
               acc_overflow  = recv_st.full;
               recv_ctl.push = !recv_st.full;
               timer_in      = recv_st.full ? 8'd0 : idle_ticks_ff;
            end
            urbif_pkg::OP_TICK: begin
               acc_hit      = req_line_ready && !send_st.empty;
               send_ctl.pop = req_line_ready && !send_st.empty;
               if (timer_ff != 8'd0) begin
                  timer_in  = timer_ff - 8'd1;
                  acc_frame = (timer_ff == 8'd1);
               end
            end
            default: begin
               acc_hit = 1'b0;
            end
         endcase
      end

      if (finish && (op_ff == urbif_pkg::OP_WRITE) && cr_ff && hit_ff) begin
         send_ctl.push = !send_st.full;
      end
   end

   always_comb begin
      case (op_ff)
         urbif_pkg::OP_WRITE: fin_ok = cr_ff ? (hit_ff && !send_st.full) : hit_ff;
         urbif_pkg::OP_READ:  fin_ok = hit_ff;
         default:             fin_ok = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         timer_ff      <= 8'd0;
         idle_ticks_ff <= urbif_pkg::IDLE_RESET;
      end else begin
         timer_ff <= timer_in;
         if (csr_valid && csr_ready) begin
            idle_ticks_ff <= csr_idle_ticks;
         end
         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  state_ff    <= ST_WORK;
                  op_ff       <= req_op;
                  data_ff     <= req_data_byte;
                  cr_ff       <= need_cr;
                  hit_ff      <= acc_hit;
                  frame_ff    <= acc_frame;
                  overflow_ff <= acc_overflow;
               end
            end
            ST_WORK: begin
               if (finish) begin
                  state_ff           <= ST_IDLE;
                  rsp_ok_ff          <= fin_ok;
                  rsp_read_byte_ff   <= ((op_ff == urbif_pkg::OP_READ) && hit_ff) ?
                                        recv_rd : 8'd0;
                  rsp_send_valid_ff  <= (op_ff == urbif_pkg::OP_TICK) && hit_ff;
                  rsp_send_byte_ff   <= ((op_ff == urbif_pkg::OP_TICK) && hit_ff) ?
                                        send_rd : 8'd0;
                  rsp_frame_ready_ff <= frame_ff;
                  rsp_frame_count_ff <= frame_ff ? urbif_pkg::sat_count(recv_st.fill) : 8'd0;
                  rsp_overflow_ff    <= overflow_ff;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   urbif_ring u_send_ring (
      .clock     (clock),
      .reset     (reset),
      .ctl       (send_ctl),
      .push_data (send_push_data),
      .status    (send_st),
      .rd_data   (send_rd)
   );

   urbif_ring u_recv_ring (
      .clock     (clock),
      .reset     (reset),
      .ctl       (recv_ctl),
      .push_data (req_data_byte),
      .status    (recv_st),
      .rd_data   (recv_rd)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_read_byte   = rsp_read_byte_ff;
   assign rsp_send_valid  = rsp_send_valid_ff;
   assign rsp_send_byte   = rsp_send_byte_ff;
   assign rsp_frame_ready = rsp_frame_ready_ff;
   assign rsp_frame_count = rsp_frame_count_ff;
   assign rsp_overflow    = rsp_overflow_ff;

   `ASSERT_CLK(a_xfer_work, req_xfer |=> (state_ff == ST_WORK), "transfer did not start work")
   `ASSERT_CLK(a_finish_rsp, finish |=> rsp_valid_ff, "finished item left no response")
   `ASSERT_NEVER(a_send_ok, rsp_valid_ff && rsp_send_valid_ff && rsp_ok_ff, "send and ok together")
   `ASSERT_NEVER(a_ovf_frame, rsp_valid_ff && rsp_overflow_ff && !rsp_frame_ready_ff, "overflow without frame")

endmodule

`default_nettype wire
